// ----- design/sdg_pkg.sv -----
// Shared types and constants for the SVPWM duty generator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sdg_pkg;

	// field widths
	localparam int VOLT_W    = 16;
	localparam int DUTY_W    = 16;
	localparam int TRIG_W    = 16;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;
	localparam int MAG_W     = 32;
	localparam int PROD_W    = 2 * VOLT_W;
	localparam int AB_W      = PROD_W + 1;
	localparam int PH_W      = 52;
	localparam int SH_W      = 54;
	localparam int A_W       = SH_W - 16;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_UDC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIM = 2'd1;
	localparam logic [CFG_W-1:0] UDC_RESET = 15'd6144;
	localparam logic [CFG_W-1:0] LIM_RESET = 15'd3547;

	// sqrt(3)/2 in Q0.16
	localparam logic signed [17:0] SQRT3_HALF = 18'sd56756;

	localparam logic [DUTY_W-1:0] DUTY_HALF = 16'h8000;
	localparam logic [DUTY_W-1:0] DUTY_FULL = 16'hFFFF;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// two bits per step, eight steps per 16-bit result
	localparam logic [2:0] STEP_LAST = 3'd7;

	// one classified word in the queue
	typedef struct packed {
		logic signed [VOLT_W-1:0] d;
		logic signed [VOLT_W-1:0] q;
		logic signed [TRIG_W-1:0] sn;
		logic signed [TRIG_W-1:0] cs;
		logic                     skip;
		logic                     limit;
		logic [MAG_W-1:0]         mag2;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQRT,
		ST_SCALE_MUL,
		ST_SCALE_DIV,
		ST_PARK_MUL,
		ST_PARK_SUM,
		ST_CLARKE,
		ST_PHASE,
		ST_EXTREME,
		ST_SHIFT,
		ST_DUTY_INIT,
		ST_DUTY_DIV,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ----- design/sdg_front.sv -----
// Front end: accepts input words, squares the dq command and classifies it
// (skip / needs limiting). Depends on sdg_pkg.
`default_nettype none

module sdg_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [63:0]                   s_tdata,
	input  wire logic [sdg_pkg::CFG_W-1:0]     lim,
	input  wire logic [sdg_pkg::QCNT_W-1:0]    qcount,
	output logic                               push,
	output sdg_pkg::item_t                     item
);

	logic                 v_s1_q, v_s2_q;
	logic signed [15:0]   d_s1, q_s1, sn_s1, cs_s1;
	logic [31:0]          sqd_s1, sqq_s1;
	logic [29:0]          lim2_s1;
	logic                 skip_s1;
	sdg_pkg::item_t       item_s2;
	logic [15:0]          ud, uq;
	logic                 take;
	logic [31:0]          mag2;

	// credit check: queue entries plus words in flight stay within depth
	assign s_tready = (qcount + sdg_pkg::QCNT_W'(v_s1_q) + sdg_pkg::QCNT_W'(v_s2_q))
		< sdg_pkg::QCNT_W'(sdg_pkg::QUEUE_DEPTH);
	assign take = s_tvalid & s_tready;

	assign ud = s_tdata[15] ? 16'(-s_tdata[15:0]) : s_tdata[15:0];
	assign uq = s_tdata[31] ? 16'(-s_tdata[31:16]) : s_tdata[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			v_s1_q <= take;
			v_s2_q <= v_s1_q;
		end
	end

	// stage 1: squares
	always_ff @(posedge clk) begin
		d_s1    <= s_tdata[15:0];
		q_s1    <= s_tdata[31:16];
		sn_s1   <= s_tdata[47:32];
		cs_s1   <= s_tdata[63:48];
		sqd_s1  <= 32'(ud) * 32'(ud);
		sqq_s1  <= 32'(uq) * 32'(uq);
		lim2_s1 <= 30'(lim) * 30'(lim);
		skip_s1 <= (lim == '0);
	end

	// stage 2: magnitude compare
	assign mag2 = sqd_s1 + sqq_s1;

	always_ff @(posedge clk) begin
		item_s2.d     <= d_s1;
		item_s2.q     <= q_s1;
		item_s2.sn    <= sn_s1;
		item_s2.cs    <= cs_s1;
		item_s2.skip  <= skip_s1;
		item_s2.mag2  <= mag2;
		item_s2.limit <= mag2 > {2'b00, lim2_s1};
	end

	assign push = v_s2_q;
	assign item = item_s2;

endmodule

`default_nettype wire

// ----- design/sdg_queue.sv -----
// Short queue of classified words between front and back end.
// Depends on sdg_pkg.
`default_nettype none

module sdg_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire sdg_pkg::item_t              wr_item,
	input  wire logic                        pop,
	output logic                             rd_valid,
	output sdg_pkg::item_t                   rd_item,
	output logic [sdg_pkg::QCNT_W-1:0]       count
);

	sdg_pkg::item_t                    mem_q [sdg_pkg::QUEUE_DEPTH];
	logic [sdg_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
	logic [sdg_pkg::QCNT_W-1:0]        count_q;

	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign count    = count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + sdg_pkg::QCNT_W'(push) - sdg_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

`default_nettype wire

// ----- design/sdg_back.sv -----
// Back end: sequencer that limits the dq vector (sqrt and divide units),
// runs inverse Park/Clarke, min-max injection and the duty divides.
// Depends on sdg_pkg.
`default_nettype none

module sdg_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_valid,
	input  wire sdg_pkg::item_t             q_item,
	output logic                            q_pop,
	input  wire logic [sdg_pkg::CFG_W-1:0]  udc,
	input  wire logic [sdg_pkg::CFG_W-1:0]  lim,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [79:0]                     m_tdata,
	output logic                            m_tuser
);

	sdg_pkg::state_t st_q, st_d;
	logic [2:0]      cnt_q;
	logic            last;
	logic            emit;

	// working registers
	logic signed [15:0] d_q, q_q, sn_q, cs_q;
	logic               neg_d_q, neg_q_q, skip_q;
	logic [31:0]        rad_q;
	logic [17:0]        srem_q;
	logic [15:0]        root_q;
	logic [15:0]        drem_q [2];
	logic [15:0]        dlo_q  [2];
	logic signed [31:0] p_dc_q, p_qs_q, p_ds_q, p_qc_q;
	logic signed [sdg_pkg::AB_W-1:0] alpha_q, beta_q;
	logic signed [sdg_pkg::PH_W-1:0] ph_q [3];
	logic signed [sdg_pkg::SH_W-1:0] mxmn_q;
	logic signed [sdg_pkg::SH_W-1:0] s_q [3];
	logic [14:0]        urem_q [3];
	logic [15:0]        ulo_q  [3];
	logic               ovf_q  [3];
	logic               neg_q  [3];
	logic               zero_q [3];
	logic [15:0]        held_q [3];

	// output register
	logic               out_v_q;
	logic [79:0]        out_data_q;
	logic               out_skip_q;

	// combinational helpers
	logic [19:0]        sr, tr;
	logic [15:0]        rt;
	logic [31:0]        rad_n;
	logic [15:0]        ud, uq;
	logic [30:0]        nd, nq;
	logic [31:0]        sdn [2];
	logic [30:0]        udn [3];
	logic signed [50:0] bprod;
	logic signed [sdg_pkg::PH_W-1:0] ph1_n, ph2_n, mx, mn;
	logic signed [sdg_pkg::SH_W-1:0] sabs [3];
	logic [15:0]        duty [3];

	// two restoring divide steps, 16-bit divisor
	function automatic logic [31:0] div2_16(input logic [15:0] rem, input logic [15:0] lo,
		input logic [15:0] dv);
		logic [16:0] r;
		logic [15:0] rm, l;
		rm = rem;
		l  = lo;
		for (int k = 0; k < 2; k++) begin
			r = {rm, l[15]};
			l = {l[14:0], 1'b0};
			if (r >= {1'b0, dv}) begin
				r    = r - {1'b0, dv};
				l[0] = 1'b1;
			end
			rm = r[15:0];
		end
		return {rm, l};
	endfunction

	// two restoring divide steps, 15-bit divisor
	function automatic logic [30:0] div2_15(input logic [14:0] rem, input logic [15:0] lo,
		input logic [14:0] dv);
		logic [15:0] r;
		logic [14:0] rm;
		logic [15:0] l;
		rm = rem;
		l  = lo;
		for (int k = 0; k < 2; k++) begin
			r = {rm, l[15]};
			l = {l[14:0], 1'b0};
			if (r >= {1'b0, dv}) begin
				r    = r - {1'b0, dv};
				l[0] = 1'b1;
			end
			rm = r[14:0];
		end
		return {rm, l};
	endfunction

	// half plus or minus the quotient, saturated
	function automatic logic [15:0] duty_of(input logic zero, input logic ovf,
		input logic neg, input logic [15:0] qt);
		logic [16:0] v;
		v = '0;
		if (zero) begin
			return sdg_pkg::DUTY_HALF;
		end else if (ovf) begin
			return neg ? '0 : sdg_pkg::DUTY_FULL;
		end else if (neg) begin
			if (qt > sdg_pkg::DUTY_HALF) return '0;
			v = {1'b0, sdg_pkg::DUTY_HALF} - {1'b0, qt};
			return v[15:0];
		end else begin
			v = {1'b0, sdg_pkg::DUTY_HALF} + {1'b0, qt};
			return v[16] ? sdg_pkg::DUTY_FULL : v[15:0];
		end
	endfunction

	assign last = (cnt_q == sdg_pkg::STEP_LAST);
	assign emit = (st_q == sdg_pkg::ST_EMIT) && (!out_v_q || m_tready);
	assign q_pop = (st_q == sdg_pkg::ST_IDLE) && q_valid;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= sdg_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == sdg_pkg::ST_SQRT || st_q == sdg_pkg::ST_SCALE_DIV ||
			    st_q == sdg_pkg::ST_DUTY_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			sdg_pkg::ST_IDLE: begin
				if (q_valid) begin
					if (q_item.skip)       st_d = sdg_pkg::ST_EMIT;
					else if (q_item.limit) st_d = sdg_pkg::ST_SQRT;
					else                   st_d = sdg_pkg::ST_PARK_MUL;
				end
			end
			sdg_pkg::ST_SQRT:      if (last) st_d = sdg_pkg::ST_SCALE_MUL;
			sdg_pkg::ST_SCALE_MUL: st_d = sdg_pkg::ST_SCALE_DIV;
			sdg_pkg::ST_SCALE_DIV: if (last) st_d = sdg_pkg::ST_PARK_MUL;
			sdg_pkg::ST_PARK_MUL:  st_d = sdg_pkg::ST_PARK_SUM;
			sdg_pkg::ST_PARK_SUM:  st_d = sdg_pkg::ST_CLARKE;
			sdg_pkg::ST_CLARKE:    st_d = sdg_pkg::ST_PHASE;
			sdg_pkg::ST_PHASE:     st_d = sdg_pkg::ST_EXTREME;
			sdg_pkg::ST_EXTREME:   st_d = sdg_pkg::ST_SHIFT;
			sdg_pkg::ST_SHIFT:     st_d = sdg_pkg::ST_DUTY_INIT;
			sdg_pkg::ST_DUTY_INIT: st_d = sdg_pkg::ST_DUTY_DIV;
			sdg_pkg::ST_DUTY_DIV:  if (last) st_d = sdg_pkg::ST_EMIT;
			sdg_pkg::ST_EMIT:      if (emit) st_d = sdg_pkg::ST_IDLE;
			default:               st_d = sdg_pkg::ST_IDLE;
		endcase
	end

	// square root, two result bits per step
	always_comb begin
		sr    = {2'b00, srem_q};
		rt    = root_q;
		rad_n = rad_q;
		tr    = '0;
		for (int k = 0; k < 2; k++) begin
			sr = {sr[17:0], rad_n[31:30]};
			tr = {2'b00, rt, 2'b01};
			if (sr >= tr) begin
				sr = sr - tr;
				rt = {rt[14:0], 1'b1};
			end else begin
				rt = {rt[14:0], 1'b0};
			end
			rad_n = {rad_n[29:0], 2'b00};
		end
	end

	// magnitude scaling products and divide steps
	assign ud = neg_d_q ? 16'(-d_q) : d_q;
	assign uq = neg_q_q ? 16'(-q_q) : q_q;
	assign nd = 31'(ud) * 31'(lim);
	assign nq = 31'(uq) * 31'(lim);
	assign sdn[0] = div2_16(drem_q[0], dlo_q[0], root_q);
	assign sdn[1] = div2_16(drem_q[1], dlo_q[1], root_q);

	// Clarke and phase C
	assign bprod = beta_q * sdg_pkg::SQRT3_HALF;
	assign ph1_n = sdg_pkg::PH_W'(bprod) - (sdg_pkg::PH_W'(alpha_q) <<< 15);
	assign ph2_n = -ph_q[0] - ph_q[1];

	// min and max of the three phases
	always_comb begin
		mx = ph_q[0];
		mn = ph_q[0];
		for (int i = 1; i < 3; i++) begin
			if (ph_q[i] > mx) mx = ph_q[i];
			if (ph_q[i] < mn) mn = ph_q[i];
		end
	end

	// per-phase lanes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sabs[i] = s_q[i][sdg_pkg::SH_W-1] ? -s_q[i] : s_q[i];
			udn[i]  = div2_15(urem_q[i], ulo_q[i], udc);
			duty[i] = duty_of(zero_q[i], ovf_q[i], neg_q[i], ulo_q[i]);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			sdg_pkg::ST_IDLE: begin
				d_q     <= q_item.d;
				q_q     <= q_item.q;
				sn_q    <= q_item.sn;
				cs_q    <= q_item.cs;
				skip_q  <= q_item.skip;
				neg_d_q <= q_item.d[15];
				neg_q_q <= q_item.q[15];
				rad_q   <= q_item.mag2;
				srem_q  <= '0;
				root_q  <= '0;
			end
			sdg_pkg::ST_SQRT: begin
				rad_q  <= rad_n;
				srem_q <= sr[17:0];
				root_q <= rt;
			end
			sdg_pkg::ST_SCALE_MUL: begin
				drem_q[0] <= {2'b00, nd[29:16]};
				dlo_q[0]  <= nd[15:0];
				drem_q[1] <= {2'b00, nq[29:16]};
				dlo_q[1]  <= nq[15:0];
			end
			sdg_pkg::ST_SCALE_DIV: begin
				drem_q[0] <= sdn[0][31:16];
				dlo_q[0]  <= sdn[0][15:0];
				drem_q[1] <= sdn[1][31:16];
				dlo_q[1]  <= sdn[1][15:0];
				if (last) begin
					d_q <= neg_d_q ? 16'(-sdn[0][15:0]) : sdn[0][15:0];
					q_q <= neg_q_q ? 16'(-sdn[1][15:0]) : sdn[1][15:0];
				end
			end
			sdg_pkg::ST_PARK_MUL: begin
				p_dc_q <= d_q * cs_q;
				p_qs_q <= q_q * sn_q;
				p_ds_q <= d_q * sn_q;
				p_qc_q <= q_q * cs_q;
			end
			sdg_pkg::ST_PARK_SUM: begin
				alpha_q <= sdg_pkg::AB_W'(p_dc_q) - sdg_pkg::AB_W'(p_qs_q);
				beta_q  <= sdg_pkg::AB_W'(p_ds_q) + sdg_pkg::AB_W'(p_qc_q);
			end
			sdg_pkg::ST_CLARKE: begin
				ph_q[0] <= sdg_pkg::PH_W'(alpha_q) <<< 16;
				ph_q[1] <= ph1_n;
			end
			sdg_pkg::ST_PHASE: begin
				ph_q[2] <= ph2_n;
			end
			sdg_pkg::ST_EXTREME: begin
				mxmn_q <= sdg_pkg::SH_W'(mx) + sdg_pkg::SH_W'(mn);
			end
			sdg_pkg::ST_SHIFT: begin
				for (int i = 0; i < 3; i++) begin
					s_q[i] <= (sdg_pkg::SH_W'(ph_q[i]) <<< 1) - mxmn_q;
				end
			end
			sdg_pkg::ST_DUTY_INIT: begin
				// quotient of |s| / (udc << 16), overflow when it needs more than 16 bits
				for (int i = 0; i < 3; i++) begin
					neg_q[i]  <= s_q[i][sdg_pkg::SH_W-1];
					zero_q[i] <= (s_q[i] == '0);
					ovf_q[i]  <= sabs[i][sdg_pkg::SH_W-1:32] >= {7'd0, udc};
					urem_q[i] <= sabs[i][46:32];
					ulo_q[i]  <= sabs[i][31:16];
				end
			end
			sdg_pkg::ST_DUTY_DIV: begin
				for (int i = 0; i < 3; i++) begin
					urem_q[i] <= udn[i][30:16];
					ulo_q[i]  <= udn[i][15:0];
				end
			end
			default: begin
			end
		endcase
	end

	// held duties and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			held_q[0] <= '0;
			held_q[1] <= '0;
			held_q[2] <= '0;
		end else begin
			if (emit) begin
				out_v_q <= 1'b1;
				if (!skip_q) begin
					held_q[0] <= duty[0];
					held_q[1] <= duty[1];
					held_q[2] <= duty[2];
				end
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_skip_q <= skip_q;
			if (skip_q) out_data_q <= {q_q, d_q, held_q[2], held_q[1], held_q[0]};
			else        out_data_q <= {q_q, d_q, duty[2], duty[1], duty[0]};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_skip_q;

endmodule

`default_nettype wire

// ----- design/svpwm_duty_generator_top.sv -----
// Top level of the SVPWM duty generator: configuration registers, front end,
// queue and back end. Depends on sdg_pkg, sdg_front, sdg_queue, sdg_back.
`default_nettype none

// SVPWM duty generator with min-max zero-sequence injection. A word on the
// slave stream carries a dq voltage command (Q7.8) and sine/cosine of the
// angle (Q1.15); one word on the master stream returns three duties (Q0.16),
// the limited dq voltages and a skip flag in tuser. The front end takes a
// word every cycle while the four-entry queue, with words in flight, has
// room; the back end is a sequencer that handles one word at a time:
// straight to output when the vector limit is zero, else inverse Park/Clarke,
// injection and the duty divide by the bus voltage, after a scale-down when
// the vector exceeds the limit (square root and two divides, two bits per
// cycle each). Configuration writes are taken at any time and must only be
// issued while the block is idle.
module svpwm_duty_generator_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [63:0]                       s_tdata,  // d_voltage, q_voltage, sin_angle, cos_angle
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [79:0]                            m_tdata,  // duty_a, duty_b, duty_c, limited_d, limited_q
	output logic                                   m_tuser,  // skipped
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sdg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sdg_pkg::CFG_W-1:0]         cfg_data
);

	logic [sdg_pkg::CFG_W-1:0]  udc_q, lim_q;
	logic                       push, pop, q_valid;
	sdg_pkg::item_t             f_item, q_item;
	logic [sdg_pkg::QCNT_W-1:0] qcount;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			udc_q <= sdg_pkg::UDC_RESET;
			lim_q <= sdg_pkg::LIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				sdg_pkg::REG_UDC: udc_q <= cfg_data;
				sdg_pkg::REG_LIM: lim_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sdg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.lim      (lim_q),
		.qcount   (qcount),
		.push     (push),
		.item     (f_item)
	);

	sdg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (f_item),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_item  (q_item),
		.count    (qcount)
	);

	sdg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (pop),
		.udc      (udc_q),
		.lim      (lim_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for svpwm_duty_generator_top: drives dq/angle words,
// predicts duties, limited dq and the skip flag, and checks every output word.
// Depends on sdg_pkg and the design sources only.
`default_nettype none

module tb_top;

	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [15:0]        duty_a;
		logic [15:0]        duty_b;
		logic [15:0]        duty_c;
		logic signed [15:0] lim_d;
		logic signed [15:0] lim_q;
		logic               skipped;
	} duty_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;       // d_voltage, q_voltage, sin_angle, cos_angle
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;            // duty_a, duty_b, duty_c, limited_d, limited_q
	logic        m_tuser;            // skipped
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [sdg_pkg::CFG_IDX_W-1:0] cfg_index = sdg_pkg::REG_UDC;
	logic [sdg_pkg::CFG_W-1:0]     cfg_data = '0;

	// predictor state
	longint     bus_setting = sdg_pkg::UDC_RESET;
	longint     limit_setting = sdg_pkg::LIM_RESET;
	logic [15:0] held_duty [3] = '{default: '0};
	duty_word_t pending_duties [$];

	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req_cnt = 0;
	int hold_done_cnt = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	svpwm_duty_generator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// integer square root, floor
	function automatic longint int_sqrt(longint v);
		longint r, t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= v) r = t;
		end
		return r;
	endfunction

	// one axis scaled onto the limit, truncated toward zero
	function automatic longint scale_axis(longint x, longint lim, longint m);
		longint ux;
		ux = (x < 0) ? -x : x;
		return (x < 0) ? -(ux * lim / m) : (ux * lim / m);
	endfunction

	// shifted phase (Q.39 doubled) over bus voltage, saturated duty
	function automatic logic [15:0] phase_duty(longint s);
		longint den, mag, v;
		if (bus_setting == 0) begin
			if (s > 0) return sdg_pkg::DUTY_FULL;
			if (s < 0) return '0;
			return sdg_pkg::DUTY_HALF;
		end
		den = bus_setting << 16;
		mag = (s < 0) ? -s : s;
		v = (s < 0) ? 32768 - mag / den : 32768 + mag / den;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return v[15:0];
	endfunction

	// expected output word for one command, updates held duties
	function automatic duty_word_t predict_duties(logic signed [15:0] d_in,
			logic signed [15:0] q_in, logic signed [15:0] sn_in, logic signed [15:0] cs_in);
		longint d, q, sn, cs, alpha, beta, mx, mn, mag2;
		longint ph [3];
		logic [15:0] dt [3];
		duty_word_t r;
		d = d_in; q = q_in; sn = sn_in; cs = cs_in;
		r.lim_d = d_in;
		r.lim_q = q_in;
		if (limit_setting == 0) begin
			r.duty_a = held_duty[0]; r.duty_b = held_duty[1]; r.duty_c = held_duty[2];
			r.skipped = 1'b1;
			return r;
		end
		mag2 = d * d + q * q;
		if (mag2 > limit_setting * limit_setting) begin
			d = scale_axis(d, limit_setting, int_sqrt(mag2));
			q = scale_axis(q, limit_setting, int_sqrt(mag2));
		end
		alpha = d * cs - q * sn;
		beta = d * sn + q * cs;
		ph[0] = alpha * 65536;
		ph[1] = -alpha * 32768 + beta * 56756;
		ph[2] = -ph[0] - ph[1];
		mx = ph[0]; mn = ph[0];
		for (int i = 1; i < 3; i++) begin
			if (ph[i] > mx) mx = ph[i];
			if (ph[i] < mn) mn = ph[i];
		end
		for (int i = 0; i < 3; i++) begin
			dt[i] = phase_duty(2 * ph[i] - (mx + mn));
			held_duty[i] = dt[i];
		end
		r.duty_a = dt[0]; r.duty_b = dt[1]; r.duty_c = dt[2];
		r.lim_d = d[15:0];
		r.lim_q = q[15:0];
		r.skipped = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// offer one command word until accepted
	task automatic send_command(logic [15:0] d, logic [15:0] q, logic [15:0] sn,
			logic [15:0] cs);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {cs, sn, q, d};
		do @(posedge clk); while (!s_tready);
		pending_duties.push_back(predict_duties(d, q, sn, cs));
	endtask

	// register write while idle
	task automatic write_reg(logic [sdg_pkg::CFG_IDX_W-1:0] idx,
			logic [sdg_pkg::CFG_W-1:0] val);
		s_tvalid <= 1'b0;
		wait (pending_duties.size() == 0);
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == sdg_pkg::REG_UDC) bus_setting = val;
		else limit_setting = val;
	endtask

	task automatic send_random(int n);
		logic [15:0] d, q;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) == 0) begin
				d = 16'($urandom); q = 16'($urandom);
			end else begin
				d = 16'($urandom_range(0, 8000) - 4000);
				q = 16'($urandom_range(0, 8000) - 4000);
			end
			send_command(d, q, 16'($urandom), 16'($urandom));
		end
	endtask

	task automatic test_directed();
		send_command(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
		send_command(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_command(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_command(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		send_command(16'h0400, 16'hFC00, 16'h5A82, 16'h5A82);
		send_command(16'h0000, 16'h0D00, 16'h0000, 16'h7FFF);
		send_command(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
		// bus voltage zero: duties go to rails or one half
		write_reg(sdg_pkg::REG_UDC, 15'd0);
		send_command(16'h0100, 16'h0200, 16'h4000, 16'h6ED9);
		send_command(16'h0000, 16'h0000, 16'h4000, 16'h6ED9);
		send_command(16'h8000, 16'h7FFF, 16'h8000, 16'h0000);
		// tiny bus voltage, widest limit
		write_reg(sdg_pkg::REG_UDC, 15'd1);
		write_reg(sdg_pkg::REG_LIM, 15'h7FFF);
		send_command(16'h7FFF, 16'h8000, 16'h1234, 16'h7000);
		send_command(16'h0003, 16'hFFFD, 16'h7FFF, 16'h0000);
		// limit zero: duties held, dq echoed
		write_reg(sdg_pkg::REG_LIM, 15'd0);
		send_command(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		send_command(16'h1234, 16'hABCD, 16'h0000, 16'h0000);
		// limit of one
		write_reg(sdg_pkg::REG_UDC, 15'h7FFF);
		write_reg(sdg_pkg::REG_LIM, 15'd1);
		send_command(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF);
		send_command(16'h0001, 16'h0000, 16'h2000, 16'h7000);
		send_command(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		write_reg(sdg_pkg::REG_UDC, sdg_pkg::UDC_RESET);
		write_reg(sdg_pkg::REG_LIM, sdg_pkg::LIM_RESET);
	endtask

	task automatic test_random();
		send_idle_pct = 23; recv_idle_pct = 47;
		send_random(300);
		write_reg(sdg_pkg::REG_UDC, 15'd2000);
		write_reg(sdg_pkg::REG_LIM, 15'd1500);
		send_random(150);
		send_idle_pct = 47; recv_idle_pct = 23;
		write_reg(sdg_pkg::REG_UDC, 15'($urandom));
		write_reg(sdg_pkg::REG_LIM, 15'($urandom));
		send_random(300);
		write_reg(sdg_pkg::REG_LIM, 15'd0);
		send_random(60);
		send_idle_pct = 0; recv_idle_pct = 0;
		write_reg(sdg_pkg::REG_UDC, 15'h7FFF);
		write_reg(sdg_pkg::REG_LIM, 15'h7FFF);
		send_random(200);
		write_reg(sdg_pkg::REG_UDC, sdg_pkg::UDC_RESET);
		write_reg(sdg_pkg::REG_LIM, sdg_pkg::LIM_RESET);
		send_random(250);
	endtask

	// receiver stalls long while commands keep coming, so the queue fills
	task automatic test_backpressure();
		hold_req_cnt++;
		send_random(30);
	endtask

	// receiver ready with random stalls and the long hold-off
	always @(posedge clk) begin
		if (hold_req_cnt != hold_done_cnt) begin
			hold_done_cnt <= hold_req_cnt;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// output word check against the oldest prediction
	always @(posedge clk) begin
		duty_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_duties.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				want = pending_duties.pop_front();
				if (m_tdata[15:0] != want.duty_a)
					report_mismatch("duty_a", m_tdata[15:0], want.duty_a);
				if (m_tdata[31:16] != want.duty_b)
					report_mismatch("duty_b", m_tdata[31:16], want.duty_b);
				if (m_tdata[47:32] != want.duty_c)
					report_mismatch("duty_c", m_tdata[47:32], want.duty_c);
				if (m_tdata[63:48] != want.lim_d)
					report_mismatch("limited_d", $signed(m_tdata[63:48]), want.lim_d);
				if (m_tdata[79:64] != want.lim_q)
					report_mismatch("limited_q", $signed(m_tdata[79:64]), want.lim_q);
				if (m_tuser != want.skipped)
					report_mismatch("skipped", m_tuser, want.skipped);
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		wait (pending_duties.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
